>>> rtl/nearest_centroid_track_table_top_assert.svh
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef NEAREST_CENTROID_TRACK_TABLE_TOP_ASSERT_SVH
`define NEAREST_CENTROID_TRACK_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define NCTT_ASSERT_HOLDS(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("nctt check failed");

// next-cycle implication
`define NCTT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("nctt check failed");

`endif

>>> rtl/nctt_pkg.sv
// types, codes and helpers of the track table
// no dependencies
package nctt_pkg;

    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int DIST_W = 33;

    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_MATCHED    = 3'd0,
        ST_CREATED    = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_READ_VALID = 3'd3,
        ST_READ_EMPTY = 3'd4,
        ST_CLEARED    = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        REG_MERGE_RADIUS  = 1'b0,
        REG_MIN_SIGHTINGS = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        VK_CLEAR_ALL = 2'd0,
        VK_CLEAR_ROW = 2'd1,
        VK_BUMP      = 2'd2,
        VK_SCAN      = 2'd3
    } vkind_t;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic        side;
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] sight;
        logic [15:0] named;
    } track_t;

    typedef struct packed {
        logic              valid;
        logic              rd_mode;
        logic [IDX_W-1:0]  tgt;
        logic              found;
        logic [DIST_W-1:0] best_d;
        logic [IDX_W-1:0]  idx;
        track_t            trk;
    } srch_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        track_t           trk;
    } upd_t;

    typedef struct packed {
        logic             start;
        vkind_t           kind;
        logic [IDX_W-1:0] track;
        logic [IDX_W-1:0] label;
    } vcmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [IDX_W-1:0] top_label;
        logic [15:0]      top_votes;
    } vstat_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

>>> rtl/nctt_cell.sv
// one track cell: holds a track, its distance to the detection, one search stage
// depends on nctt_pkg
module nctt_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [nctt_pkg::IDX_W-1:0]      cell_idx,
    input  logic [nctt_pkg::CNT_W-1:0]      live_count,
    input  logic [15:0]                     det_x,
    input  logic [15:0]                     det_y,
    input  nctt_pkg::upd_t                  upd,
    input  nctt_pkg::srch_t                 srch_in,
    output nctt_pkg::srch_t                 srch_out
);

    nctt_pkg::track_t                  trk_reg;
    logic [nctt_pkg::DIST_W-1:0]       d_reg;
    logic [nctt_pkg::DIST_W-1:0]       d_next;
    nctt_pkg::srch_t                   srch_reg;
    nctt_pkg::srch_t                   srch_next;
    logic [15:0]                       ax;
    logic [15:0]                       ay;
    logic [31:0]                       sx;
    logic [31:0]                       sy;
    logic                              live;

    assign live = {1'b0, cell_idx} < live_count;

    always_comb
    begin
        ax     = (trk_reg.cx >= det_x) ? trk_reg.cx - det_x : det_x - trk_reg.cx;
        ay     = (trk_reg.cy >= det_y) ? trk_reg.cy - det_y : det_y - trk_reg.cy;
        sx     = 32'(ax) * 32'(ax);
        sy     = 32'(ay) * 32'(ay);
        d_next = {1'b0, sx} + {1'b0, sy};
    end

    always_comb
    begin
        srch_next = srch_in;
        if (srch_in.valid)
        begin
            if (srch_in.rd_mode)
            begin
                if (srch_in.tgt == cell_idx && live)
                begin
                    srch_next.found = 1'b1;
                    srch_next.idx   = cell_idx;
                    srch_next.trk   = trk_reg;
                end
            end
            else if (live && d_reg < srch_in.best_d)
            begin
                srch_next.best_d = d_reg;
                srch_next.found  = 1'b1;
                srch_next.idx    = cell_idx;
                srch_next.trk    = trk_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.we && upd.idx == cell_idx)
        begin
            trk_reg <= upd.trk;
        end
        d_reg <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
        end
        else
        begin
            srch_reg <= srch_next;
        end
    end

    assign srch_out = srch_reg;

endmodule

>>> rtl/nctt_div.sv
// 32 by 17 bit restoring divider, one quotient bit per cycle, 16-bit quotient
// depends on nothing; the numerator must be below the divisor times 65536
module nctt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [16:0] den,
    output logic        done,
    output logic [15:0] quo
);

    localparam logic [3:0] LAST_STEP = 4'd15;

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  step_reg;
    logic [16:0] rem_reg;
    logic [16:0] rem_next;
    logic [15:0] qsh_reg;
    logic [16:0] den_reg;
    logic [17:0] trial;
    logic        ge;

    always_comb
    begin
        trial    = {rem_reg, qsh_reg[15]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 17'(trial - {1'b0, den_reg}) : trial[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num[31:16]};
            qsh_reg <= num[15:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            qsh_reg <= {qsh_reg[14:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = qsh_reg;

endmodule

>>> rtl/nctt_votes.sv
// per-track label vote memory with row sweep: clear, bump and best-label scan
// depends on nctt_pkg
module nctt_votes #(
    parameter int MAX_TRACKS = 16,
    parameter int NUM_LABELS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  nctt_pkg::vcmd_t  cmd,
    output nctt_pkg::vstat_t stat
);

    localparam int TW    = $clog2(MAX_TRACKS);
    localparam int LW    = $clog2(NUM_LABELS);
    localparam int AW    = TW + LW;
    localparam int DEPTH = 1 << AW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [LW-1:0] LAST_LAB  = LW'(NUM_LABELS - 1);

    logic [15:0] mem [DEPTH];

    logic                          busy_reg;
    logic                          done_reg;
    logic                          iss_reg;
    logic                          b_valid_reg;
    nctt_pkg::vkind_t              kind_reg;
    logic [AW-1:0]                 cnt_reg;
    logic [TW-1:0]                 track_reg;
    logic [nctt_pkg::IDX_W-1:0]    label_reg;
    logic [LW-1:0]                 b_lab_reg;
    logic [LW-1:0]                 best_lab_reg;
    logic [15:0]                   best_v_reg;
    logic [15:0]                   rd_reg;
    logic                          b_hit;
    logic [15:0]                   b_val;
    logic                          we;
    logic [AW-1:0]                 wa;
    logic [15:0]                   wd;
    logic [AW-1:0]                 ra;

    always_comb
    begin
        b_hit = nctt_pkg::IDX_W'(b_lab_reg) == label_reg;
        unique case (kind_reg)
            nctt_pkg::VK_CLEAR_ROW: b_val = b_hit ? 16'd1 : 16'd0;
            nctt_pkg::VK_BUMP:      b_val = b_hit ? nctt_pkg::sat_inc(rd_reg) : rd_reg;
            default:                b_val = rd_reg;
        endcase
        if (kind_reg == nctt_pkg::VK_CLEAR_ALL)
        begin
            we = busy_reg;
            wa = cnt_reg;
            wd = 16'd0;
        end
        else
        begin
            we = busy_reg && b_valid_reg && kind_reg != nctt_pkg::VK_SCAN;
            wa = {track_reg, b_lab_reg};
            wd = b_val;
        end
        ra = {track_reg, cnt_reg[LW-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            iss_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
            kind_reg    <= nctt_pkg::VK_CLEAR_ALL;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (cmd.start)
                begin
                    busy_reg    <= 1'b1;
                    kind_reg    <= cmd.kind;
                    cnt_reg     <= '0;
                    iss_reg     <= cmd.kind != nctt_pkg::VK_CLEAR_ALL;
                    b_valid_reg <= 1'b0;
                end
            end
            else if (kind_reg == nctt_pkg::VK_CLEAR_ALL)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else
            begin
                b_valid_reg <= iss_reg;
                if (iss_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[LW-1:0] == LAST_LAB)
                    begin
                        iss_reg <= 1'b0;
                    end
                end
                if (b_valid_reg && b_lab_reg == LAST_LAB)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && cmd.start)
        begin
            track_reg    <= cmd.track[TW-1:0];
            label_reg    <= cmd.label;
            best_lab_reg <= '0;
            best_v_reg   <= 16'd0;
        end
        else if (busy_reg && b_valid_reg && b_lab_reg != '0 && b_val > best_v_reg)
        begin
            best_lab_reg <= b_lab_reg;
            best_v_reg   <= b_val;
        end
        b_lab_reg <= cnt_reg[LW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    always_comb
    begin
        stat.busy      = busy_reg;
        stat.done      = done_reg;
        stat.top_label = nctt_pkg::IDX_W'(best_lab_reg);
        stat.top_votes = best_v_reg;
    end

endmodule

>>> rtl/nearest_centroid_track_table_top.sv
// Track table: an input transfer brings observe, read or clear; each
// observe, read and clear gives one output transfer, op 3 gives none.
// Config over APB: merge_radius at 0x0, min_sightings at 0x4, pready tied high.
// One item at a time. The search walks the chain of MAX_TRACKS track cells one
// cell per cycle, the running mean uses two 16-bit bit-serial dividers, one per
// axis, and the label vote row (NUM_LABELS words) is swept one word per cycle.
// Steps after the input transfer: observe and read search the chain; a matched
// observe then multiplies, divides and bumps its vote row, a created observe
// clears its new row and a read that finds its slot scans the row for the best
// label; a dropped observe or an empty read goes straight to the response.
// A clear sweeps the whole vote memory, 2**(clog2(MAX_TRACKS)+clog2(NUM_LABELS))
// words (1024).
// in_ready returns in the same cycle as the result enters the output register.
// After reset the same sweep runs once and in_ready stays low for those
// cycles; config writes are taken throughout.
// The result sits in an output register: while the receiver stalls the next
// item is still accepted and worked on, and it waits only if its own result
// is ready before the previous one has been taken.
// depends on nctt_pkg, nctt_cell, nctt_div, nctt_votes
module nearest_centroid_track_table_top #(
    parameter int MAX_TRACKS = 16,
    parameter int NUM_LABELS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic        side,
    input  logic [5:0]  class_label,
    input  logic [15:0] frame_number,
    input  logic [3:0]  entry_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  track_slot,
    output logic [2:0]  status,
    output logic [15:0] mean_x,
    output logic [15:0] mean_y,
    output logic        track_side,
    output logic [15:0] first_seen,
    output logic [15:0] last_seen,
    output logic [15:0] seen_count,
    output logic [15:0] named_count,
    output logic [5:0]  top_label,
    output logic [15:0] top_votes,
    output logic        is_kept
);

    localparam int CW    = $clog2(MAX_TRACKS + 1);
    localparam int IDX_W = nctt_pkg::IDX_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIST   = 8'b0000_0010,
        S_LAUNCH = 8'b0000_0100,
        S_WAIT   = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_VOTE   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [15:0]           radius_reg;
    logic [15:0]           min_sight_reg;
    logic [CW-1:0]         count_reg;
    logic                  div_start_reg;
    logic                  out_valid_reg;

    nctt_pkg::op_t         op_reg;
    logic [15:0]           x_reg;
    logic [15:0]           y_reg;
    logic                  side_reg;
    logic [5:0]            label_reg;
    logic [15:0]           frame_reg;
    logic [3:0]            eidx_reg;
    logic [31:0]           limit_reg;
    logic [31:0]           prod_x_reg;
    logic [31:0]           prod_y_reg;
    nctt_pkg::track_t      res_trk_reg;
    logic [IDX_W-1:0]      res_slot_reg;
    nctt_pkg::status_t     res_status_reg;
    logic                  res_blank_reg;
    logic [5:0]            top_lab_reg;
    logic [15:0]           top_v_reg;

    logic [3:0]            slot_o_reg;
    logic [2:0]            status_o_reg;
    nctt_pkg::track_t      trk_o_reg;
    logic [5:0]            top_lab_o_reg;
    logic [15:0]           top_v_o_reg;
    logic                  kept_o_reg;

    logic                  accept;
    logic                  cfg_wr;
    logic                  full;
    logic                  resp_go;
    logic                  div_x_done;
    logic                  div_y_done;
    logic                  div_done;
    logic [15:0]           qx;
    logic [15:0]           qy;
    nctt_pkg::srch_t       chain [MAX_TRACKS+1];
    nctt_pkg::srch_t       chain_out;
    nctt_pkg::upd_t        upd;
    nctt_pkg::vcmd_t       vcmd;
    nctt_pkg::vstat_t      vstat;
    nctt_pkg::track_t      new_trk;
    nctt_pkg::track_t      match_trk;
    logic                  launch;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign in_ready  = state_reg == S_IDLE && !vstat.busy;
    assign accept    = in_valid && in_ready;
    assign full      = count_reg == CW'(MAX_TRACKS);
    assign chain_out = chain[MAX_TRACKS];
    assign div_done  = div_x_done && div_y_done;
    assign resp_go   = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (nctt_pkg::reg_idx_t'(paddr[2]))
            nctt_pkg::REG_MERGE_RADIUS:  prdata = {16'd0, radius_reg};
            nctt_pkg::REG_MIN_SIGHTINGS: prdata = {16'd0, min_sight_reg};
        endcase
    end

    always_comb
    begin
        new_trk.cx    = x_reg;
        new_trk.cy    = y_reg;
        new_trk.side  = side_reg;
        new_trk.first = frame_reg;
        new_trk.last  = frame_reg;
        new_trk.sight = 16'd1;
        new_trk.named = (label_reg != 6'd0) ? 16'd1 : 16'd0;

        match_trk       = res_trk_reg;
        match_trk.cx    = qx;
        match_trk.cy    = qy;
        match_trk.last  = frame_reg;
        match_trk.sight = nctt_pkg::sat_inc(res_trk_reg.sight);
        if (label_reg != 6'd0)
        begin
            match_trk.named = nctt_pkg::sat_inc(res_trk_reg.named);
        end
    end

    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = launch;
        chain[0].rd_mode = op_reg == nctt_pkg::OP_READ;
        chain[0].tgt     = IDX_W'(eidx_reg);
        chain[0].best_d  = {1'b0, limit_reg};
    end

    for (genvar i = 0; i < MAX_TRACKS; i++)
    begin : g_cell
        nctt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(i)),
            .live_count (nctt_pkg::CNT_W'(count_reg)),
            .det_x      (x_reg),
            .det_y      (y_reg),
            .upd        (upd),
            .srch_in    (chain[i]),
            .srch_out   (chain[i+1])
        );
    end

    nctt_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (prod_x_reg + 32'(x_reg)),
        .den   (17'(res_trk_reg.sight) + 17'd1),
        .done  (div_x_done),
        .quo   (qx)
    );

    nctt_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (prod_y_reg + 32'(y_reg)),
        .den   (17'(res_trk_reg.sight) + 17'd1),
        .done  (div_y_done),
        .quo   (qy)
    );

    nctt_votes #(
        .MAX_TRACKS (MAX_TRACKS),
        .NUM_LABELS (NUM_LABELS)
    ) u_votes (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (vcmd),
        .stat  (vstat)
    );

    always_comb
    begin
        state_next = state_reg;
        launch     = 1'b0;
        upd        = '0;
        vcmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (nctt_pkg::op_t'(op))
                        nctt_pkg::OP_OBSERVE,
                        nctt_pkg::OP_READ:
                        begin
                            state_next = S_DIST;
                        end
                        nctt_pkg::OP_CLEAR:
                        begin
                            vcmd.start = 1'b1;
                            vcmd.kind  = nctt_pkg::VK_CLEAR_ALL;
                            state_next = S_VOTE;
                        end
                        nctt_pkg::OP_NONE:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIST:
            begin
                state_next = S_LAUNCH;
            end
            S_LAUNCH:
            begin
                launch     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (chain_out.valid)
                begin
                    if (op_reg == nctt_pkg::OP_READ)
                    begin
                        if (chain_out.found)
                        begin
                            vcmd.start = 1'b1;
                            vcmd.kind  = nctt_pkg::VK_SCAN;
                            vcmd.track = chain_out.idx;
                            state_next = S_VOTE;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    else if (chain_out.found)
                    begin
                        state_next = S_MUL;
                    end
                    else if (full)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        upd.we     = 1'b1;
                        upd.idx    = IDX_W'(count_reg);
                        upd.trk    = new_trk;
                        vcmd.start = 1'b1;
                        vcmd.kind  = nctt_pkg::VK_CLEAR_ROW;
                        vcmd.track = IDX_W'(count_reg);
                        vcmd.label = IDX_W'(label_reg);
                        state_next = S_VOTE;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    upd.we     = 1'b1;
                    upd.idx    = res_slot_reg;
                    upd.trk    = match_trk;
                    vcmd.start = 1'b1;
                    vcmd.kind  = nctt_pkg::VK_BUMP;
                    vcmd.track = res_slot_reg;
                    vcmd.label = IDX_W'(label_reg);
                    state_next = S_VOTE;
                end
            end
            S_VOTE:
            begin
                if (vstat.done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (resp_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= 16'd1600;
            min_sight_reg <= 16'd3;
            count_reg     <= '0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_start_reg <= state_reg == S_MUL;
            if (cfg_wr)
            begin
                unique case (nctt_pkg::reg_idx_t'(paddr[2]))
                    nctt_pkg::REG_MERGE_RADIUS:  radius_reg    <= pwdata[15:0];
                    nctt_pkg::REG_MIN_SIGHTINGS: min_sight_reg <= pwdata[15:0];
                endcase
            end
            if (accept && nctt_pkg::op_t'(op) == nctt_pkg::OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if (state_reg == S_WAIT && chain_out.valid && op_reg == nctt_pkg::OP_OBSERVE
                     && !chain_out.found && !full)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_RESP && resp_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= nctt_pkg::op_t'(op);
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            side_reg  <= side;
            label_reg <= class_label;
            frame_reg <= frame_number;
            eidx_reg  <= entry_index;
            if (nctt_pkg::op_t'(op) == nctt_pkg::OP_CLEAR)
            begin
                res_status_reg <= nctt_pkg::ST_CLEARED;
                res_blank_reg  <= 1'b1;
                res_slot_reg   <= '0;
            end
        end
        if (state_reg == S_DIST)
        begin
            limit_reg <= 32'(radius_reg) * 32'(radius_reg);
        end
        if (state_reg == S_WAIT && chain_out.valid)
        begin
            res_trk_reg  <= chain_out.trk;
            res_slot_reg <= chain_out.idx;
            if (op_reg == nctt_pkg::OP_READ)
            begin
                if (chain_out.found)
                begin
                    res_status_reg <= nctt_pkg::ST_READ_VALID;
                    res_blank_reg  <= 1'b0;
                end
                else
                begin
                    res_status_reg <= nctt_pkg::ST_READ_EMPTY;
                    res_blank_reg  <= 1'b1;
                    res_slot_reg   <= IDX_W'(eidx_reg);
                end
            end
            else if (chain_out.found)
            begin
                res_status_reg <= nctt_pkg::ST_MATCHED;
                res_blank_reg  <= 1'b0;
            end
            else if (full)
            begin
                res_status_reg <= nctt_pkg::ST_DROPPED;
                res_blank_reg  <= 1'b1;
                res_slot_reg   <= '0;
            end
            else
            begin
                res_status_reg <= nctt_pkg::ST_CREATED;
                res_blank_reg  <= 1'b0;
                res_slot_reg   <= IDX_W'(count_reg);
                res_trk_reg    <= new_trk;
            end
        end
        if (state_reg == S_MUL)
        begin
            prod_x_reg <= 32'(res_trk_reg.cx) * 32'(res_trk_reg.sight);
            prod_y_reg <= 32'(res_trk_reg.cy) * 32'(res_trk_reg.sight);
        end
        if (state_reg == S_DIV && div_done)
        begin
            res_trk_reg <= match_trk;
        end
        if (state_reg == S_VOTE && vstat.done)
        begin
            top_lab_reg <= vstat.top_label[5:0];
            top_v_reg   <= vstat.top_votes;
        end
        if (state_reg == S_RESP && resp_go)
        begin
            slot_o_reg   <= res_slot_reg[3:0];
            status_o_reg <= res_status_reg;
            if (res_blank_reg)
            begin
                trk_o_reg     <= '0;
                top_lab_o_reg <= 6'd0;
                top_v_o_reg   <= 16'd0;
                kept_o_reg    <= 1'b0;
            end
            else
            begin
                trk_o_reg     <= res_trk_reg;
                top_lab_o_reg <= top_lab_reg;
                top_v_o_reg   <= top_v_reg;
                kept_o_reg    <= res_trk_reg.sight >= min_sight_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign track_slot  = slot_o_reg;
    assign status      = status_o_reg;
    assign mean_x      = trk_o_reg.cx;
    assign mean_y      = trk_o_reg.cy;
    assign track_side  = trk_o_reg.side;
    assign first_seen  = trk_o_reg.first;
    assign last_seen   = trk_o_reg.last;
    assign seen_count  = trk_o_reg.sight;
    assign named_count = trk_o_reg.named;
    assign top_label   = top_lab_o_reg;
    assign top_votes   = top_v_o_reg;
    assign is_kept     = kept_o_reg;

endmodule

>>> rtl/nctt_checker.sv
// port-level checks of the track table, bound to the top level
// depends on nctt_pkg and nearest_centroid_track_table_top_assert.svh
`include "nearest_centroid_track_table_top_assert.svh"

module nctt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  op,
    input logic [15:0] pos_x,
    input logic [15:0] pos_y,
    input logic        side,
    input logic [5:0]  class_label,
    input logic [15:0] frame_number,
    input logic [3:0]  entry_index,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  track_slot,
    input logic [2:0]  status,
    input logic [15:0] mean_x,
    input logic [15:0] mean_y,
    input logic        track_side,
    input logic [15:0] first_seen,
    input logic [15:0] last_seen,
    input logic [15:0] seen_count,
    input logic [15:0] named_count,
    input logic [5:0]  top_label,
    input logic [15:0] top_votes,
    input logic        is_kept
);

    `NCTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(track_slot))

    `NCTT_ASSERT_HOLDS(a_blank_result, out_valid && (status == nctt_pkg::ST_DROPPED || status == nctt_pkg::ST_CLEARED), track_slot == 4'd0 && mean_x == 16'd0 && seen_count == 16'd0 && top_votes == 16'd0 && !is_kept)

    `NCTT_ASSERT_HOLDS(a_created_fresh, out_valid && status == nctt_pkg::ST_CREATED, seen_count == 16'd1 && first_seen == last_seen && top_votes <= 16'd1)

    `NCTT_ASSERT_HOLDS(a_no_votes_no_label, out_valid && top_votes == 16'd0, top_label == 6'd0)

endmodule

bind nearest_centroid_track_table_top nctt_checker u_nctt_checker (.*);
